@@ sv/lncms_pkg.sv @@
// ----------------------------------------------------------------------------
// lncms_pkg
// Shared types, constants and helpers for the layered nibble count-min sketch.
// ----------------------------------------------------------------------------
package lncms_pkg;

    localparam int ROWS       = 4;
    localparam int LIGHT_AW   = 10;   // 1024 light words
    localparam int HEAVY_AW   = 8;    // 256 heavy words, all of them used
    localparam int HASH_W     = 32;
    localparam int EST_W      = 35;
    localparam int LAYERS     = 8;
    localparam int LAYER_W    = 3;
    localparam int ROW_W      = 2;
    localparam int CLR_W      = LIGHT_AW + 1;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    localparam logic [3:0] NIB_FULL = 4'hF;
    localparam logic [3:0] NIB_OVF  = 4'h8;
    localparam logic [2:0] LOW_FULL = 3'h7;

    typedef struct packed {
        logic                rd_en;
        logic [LIGHT_AW-1:0] rd_addr;
        logic                wr_en;
        logic [LIGHT_AW-1:0] wr_addr;
        logic [63:0]         wr_data;
    } light_req_t;

    typedef struct packed {
        logic                rd_en;
        logic [HEAVY_AW-1:0] rd_addr;
        logic                wr_en;
        logic [HEAVY_AW-1:0] wr_addr;
        logic [63:0]         wr_data;
    } heavy_req_t;

    // Heavy word address of layer k: layer sizes halve from 128 down to 2 words
    function automatic logic [HEAVY_AW-1:0] heavy_addr(input logic [LIGHT_AW-1:0] widx,
                                                        input logic [LAYER_W-1:0] k);
        logic [HEAVY_AW-1:0] a;
        case (k)
            3'd0:    a = {1'b0, widx[6:0]};
            3'd1:    a = 8'd128 + {2'b0, widx[5:0]};
            3'd2:    a = 8'd192 + {3'b0, widx[4:0]};
            3'd3:    a = 8'd224 + {4'b0, widx[3:0]};
            3'd4:    a = 8'd240 + {5'b0, widx[2:0]};
            3'd5:    a = 8'd248 + {6'b0, widx[1:0]};
            3'd6:    a = 8'd252 + {7'b0, widx[0]};
            default: a = 8'd254 + {7'b0, widx[0]};
        endcase
        return a;
    endfunction

    function automatic logic [3:0] get_nib(input logic [63:0] w, input logic [3:0] pos);
        return w[{pos, 2'b00} +: 4];
    endfunction

    function automatic logic [63:0] set_nib(input logic [63:0] w, input logic [3:0] pos,
                                            input logic [3:0] v);
        logic [63:0] r;
        r = w;
        r[{pos, 2'b00} +: 4] = v;
        return r;
    endfunction

endpackage

@@ sv/lncms_store.sv @@
// ----------------------------------------------------------------------------
// lncms_store
// Light and heavy counter memories with a zeroing sweep after reset.
// ----------------------------------------------------------------------------
module lncms_store
    import lncms_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  light_req_t       light_req,
    input  heavy_req_t       heavy_req,
    output logic [63:0]      light_rdata,
    output logic [63:0]      heavy_rdata,
    output logic             ready
);

    logic [63:0]      light_mem [1 << LIGHT_AW];
    logic [63:0]      heavy_mem [1 << HEAVY_AW];
    logic [CLR_W-1:0] clr_reg;
    logic [CLR_W-1:0] clr_next;
    logic             clearing;

    assign clearing = !clr_reg[LIGHT_AW];
    assign ready    = !clearing;
    assign clr_next = clr_reg + CLR_W'(1);

    // Advance the sweep counter until every light word has been zeroed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (clearing)
        begin
            clr_reg <= clr_next;
        end
    end

    // Light memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (clearing)
        begin
            light_mem[clr_reg[LIGHT_AW-1:0]] <= '0;
        end
        else if (light_req.wr_en)
        begin
            light_mem[light_req.wr_addr] <= light_req.wr_data;
        end
        if (light_req.rd_en)
        begin
            light_rdata <= light_mem[light_req.rd_addr];
        end
    end

    // Heavy memory: zeroed by the same sweep, addressed by the low bits of its counter
    always_ff @(posedge clk)
    begin
        if (clearing)
        begin
            heavy_mem[clr_reg[HEAVY_AW-1:0]] <= '0;
        end
        else if (heavy_req.wr_en)
        begin
            heavy_mem[heavy_req.wr_addr] <= heavy_req.wr_data;
        end
        if (heavy_req.rd_en)
        begin
            heavy_rdata <= heavy_mem[heavy_req.rd_addr];
        end
    end

endmodule

@@ sv/lncms_engine.sv @@
// ----------------------------------------------------------------------------
// lncms_engine
// Row sequencer: reads, updates and writes back light and heavy counters.
// ----------------------------------------------------------------------------
module lncms_engine
    import lncms_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               store_ready,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [127:0]       s_tdata,
    input  logic               s_tuser,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [EST_W-1:0]   estimate,
    output logic               saturated,
    output light_req_t         light_req,
    output heavy_req_t         heavy_req,
    input  logic [63:0]        light_rdata,
    input  logic [63:0]        heavy_rdata
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_L_RD  = 3'd1;
    localparam logic [2:0] ST_L_CHK = 3'd2;
    localparam logic [2:0] ST_H_RD  = 3'd3;
    localparam logic [2:0] ST_H_CHK = 3'd4;
    localparam logic [2:0] ST_W_RD  = 3'd5;
    localparam logic [2:0] ST_W_WR  = 3'd6;
    localparam logic [2:0] ST_END   = 3'd7;

    logic [2:0]         state_reg, state_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [LAYER_W-1:0] layer_reg, layer_next;
    logic [LAYER_W-1:0] hit_reg, hit_next;
    logic [EST_W-1:0]   acc_reg, acc_next;
    logic [EST_W-1:0]   best_reg, best_next;
    logic               sat_reg, sat_next;
    logic               kind_reg;
    logic [127:0]       hash_reg;
    logic               ovalid_reg, ovalid_next;
    logic [EST_W-1:0]   est_reg;
    logic               osat_reg;
    logic               load;

    logic [HASH_W-1:0]   hash;
    logic [LIGHT_AW-1:0] widx;
    logic [3:0]          pos;
    logic [3:0]          lnib;
    logic [3:0]          hnib;
    logic [HEAVY_AW-1:0] haddr;
    logic [EST_W-1:0]    row_min;
    logic [5:0]          shamt;

    assign hash  = hash_reg[row_reg * HASH_W +: HASH_W];
    assign widx  = hash[LIGHT_AW+3:4];
    assign pos   = hash[3:0];
    assign lnib  = get_nib(light_rdata, pos);
    assign hnib  = get_nib(heavy_rdata, pos);
    assign haddr = heavy_addr(widx, layer_reg);
    assign shamt = 6'd3 + {1'b0, layer_reg, 2'b00};
    assign row_min = (acc_reg < best_reg) ? acc_reg : best_reg;

    assign s_tready  = (state_reg == ST_IDLE) && store_ready;
    assign m_tvalid  = ovalid_reg;
    assign estimate  = est_reg;
    assign saturated = osat_reg;

    // Sequence the rows and layers
    always_comb
    begin
        state_next  = state_reg;
        row_next    = row_reg;
        layer_next  = layer_reg;
        hit_next    = hit_reg;
        acc_next    = acc_reg;
        best_next   = best_reg;
        sat_next    = sat_reg;
        load        = 1'b0;
        light_req   = '0;
        heavy_req   = '0;
        light_req.rd_addr = widx;
        light_req.wr_addr = widx;
        heavy_req.rd_addr = haddr;
        heavy_req.wr_addr = haddr;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    row_next   = '0;
                    best_next  = '1;
                    sat_next   = 1'b0;
                    state_next = ST_L_RD;
                end
            end
            ST_L_RD:
            begin
                light_req.rd_en = 1'b1;
                state_next      = ST_L_CHK;
            end
            ST_L_CHK:
            begin
                layer_next = '0;
                if (kind_reg == KIND_QUERY)
                begin
                    acc_next   = EST_W'(lnib[2:0]);
                    state_next = lnib[3] ? ST_H_RD : ST_END;
                    if (!lnib[3])
                    begin
                        acc_next = EST_W'(lnib);
                    end
                end
                else if (lnib[2:0] != LOW_FULL)
                begin
                    light_req.wr_en   = 1'b1;
                    light_req.wr_data = set_nib(light_rdata, pos, lnib + 4'd1);
                    state_next        = ST_END;
                end
                else
                begin
                    state_next = ST_H_RD;
                end
            end
            ST_H_RD:
            begin
                heavy_req.rd_en = 1'b1;
                state_next      = ST_H_CHK;
            end
            ST_H_CHK:
            begin
                if (kind_reg == KIND_QUERY)
                begin
                    acc_next   = acc_reg + (EST_W'(hnib) << shamt);
                    layer_next = layer_reg + LAYER_W'(1);
                    state_next = (layer_reg == LAYER_W'(LAYERS - 1)) ? ST_END : ST_H_RD;
                end
                else if (hnib == NIB_FULL)
                begin
                    if (layer_reg == LAYER_W'(LAYERS - 1))
                    begin
                        // Carry would leave the last layer: pin the light nibble
                        light_req.wr_en   = 1'b1;
                        light_req.wr_data = set_nib(light_rdata, pos, NIB_FULL);
                        sat_next          = 1'b1;
                        state_next        = ST_END;
                    end
                    else
                    begin
                        layer_next = layer_reg + LAYER_W'(1);
                        state_next = ST_H_RD;
                    end
                end
                else
                begin
                    light_req.wr_en   = 1'b1;
                    light_req.wr_data = set_nib(light_rdata, pos, NIB_OVF);
                    hit_next          = layer_reg;
                    layer_next        = '0;
                    state_next        = ST_W_RD;
                end
            end
            ST_W_RD:
            begin
                heavy_req.rd_en = 1'b1;
                state_next      = ST_W_WR;
            end
            ST_W_WR:
            begin
                heavy_req.wr_en = 1'b1;
                if (layer_reg == hit_reg)
                begin
                    heavy_req.wr_data = set_nib(heavy_rdata, pos, hnib + 4'd1);
                    state_next        = ST_END;
                end
                else
                begin
                    heavy_req.wr_data = set_nib(heavy_rdata, pos, 4'd0);
                    layer_next        = layer_reg + LAYER_W'(1);
                    state_next        = ST_W_RD;
                end
            end
            ST_END:
            begin
                if (kind_reg == KIND_QUERY)
                begin
                    best_next = row_min;
                end
                if (row_reg == ROW_W'(ROWS - 1))
                begin
                    if (!ovalid_reg || m_tready)
                    begin
                        load       = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    row_next   = row_reg + ROW_W'(1);
                    state_next = ST_L_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the output valid until the transfer completes
    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (m_tready)
        begin
            ovalid_next = 1'b0;
        end
        if (load)
        begin
            ovalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        row_reg   <= row_next;
        layer_reg <= layer_next;
        hit_reg   <= hit_next;
        acc_reg   <= acc_next;
        best_reg  <= best_next;
        sat_reg   <= sat_next;
        if (s_tvalid && s_tready)
        begin
            kind_reg <= s_tuser;
            hash_reg <= s_tdata;
        end
        if (load)
        begin
            est_reg  <= (kind_reg == KIND_QUERY) ? row_min : '0;
            osat_reg <= (kind_reg == KIND_INSERT) && sat_reg;
        end
    end

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!ovalid_reg || m_tready))
        else $error("result loaded over an untaken result");

    a_zero_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_W_WR) |-> (layer_reg <= hit_reg))
        else $error("zeroing walk passed the hit layer");

    a_sat_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (load && sat_reg && kind_reg == KIND_INSERT) |=> (m_tvalid && saturated))
        else $error("saturation flag lost");

    a_no_dual_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(light_req.wr_en && heavy_req.wr_en))
        else $error("light and heavy written in one cycle");

endmodule

@@ sv/layered_nibble_count_min_sketch.sv @@
// ----------------------------------------------------------------------------
// layered_nibble_count_min_sketch
// Count-min sketch of 4-bit counters with heavy overflow layers.
// ----------------------------------------------------------------------------
// Input channel s_*: tuser carries kind (0 insert, 1 query), tdata the four
// per-row hashes. Output channel m_*: one transfer per input item; tdata
// holds the estimate (zero for an insert), tuser the saturation flag.
// Rows are handled one after another through a light word read-modify-write
// in memories with a registered read. A row reads its light nibble; an insert
// with free low bits, or a query below the overflow mark, ends the row there.
// Otherwise heavy layers are read from layer 0 upward: an insert that carries
// to layer j then walks layers 0 to j, zeroing below j and incrementing j; a
// saturating insert or a query reads all eight layers. The block takes in no
// new item until the current one has finished and its result is loaded.
// After reset a sweep zeroes both memories, during which s_tready stays low.
// The result sits in an output register, so a stalled receiver only holds
// the block once the next result is ready to go out.
// ----------------------------------------------------------------------------
module layered_nibble_count_min_sketch
    import lncms_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // hash_row_0, hash_row_1, hash_row_2, hash_row_3
    input  logic         s_tuser,   // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,   // estimate, zero fill
    output logic         m_tuser    // saturated
);

    light_req_t       light_req;
    heavy_req_t       heavy_req;
    logic [63:0]      light_rdata;
    logic [63:0]      heavy_rdata;
    logic             store_ready;
    logic [EST_W-1:0] estimate;

    assign m_tdata = {5'b0, estimate};

    lncms_store u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .light_req   (light_req),
        .heavy_req   (heavy_req),
        .light_rdata (light_rdata),
        .heavy_rdata (heavy_rdata),
        .ready       (store_ready)
    );

    lncms_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .store_ready (store_ready),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .estimate    (estimate),
        .saturated   (m_tuser),
        .light_req   (light_req),
        .heavy_req   (heavy_req),
        .light_rdata (light_rdata),
        .heavy_rdata (heavy_rdata)
    );

endmodule

@@ bench/layered_nibble_count_min_sketch_test.sv @@
// ----------------------------------------------------------------------------
// layered_nibble_count_min_sketch_test
// Self-checking bench for the layered nibble count-min sketch: a local copy
// of the light and heavy counter arrays predicts each estimate and saturation
// flag, random bursts and stalls vary timing, and hot keys drive counters
// deep into the heavy layers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module layered_nibble_count_min_sketch_test;
    import lncms_pkg::*;

    localparam int LIGHT_DEPTH = 1024;
    localparam int HEAVY_DEPTH = 256;

    typedef struct packed {
        logic [EST_W-1:0] estimate;
        logic             saturated;
    } sketch_result_t;

    // Sketch scoreboard: mirrors the counters and queues expected transfers
    class sketch_scoreboard;
        logic [63:0]    light_words [LIGHT_DEPTH];
        logic [63:0]    heavy_words [HEAVY_DEPTH];
        int unsigned    layer_size [LAYERS];
        int unsigned    layer_base [LAYERS];
        sketch_result_t expected_results [$];
        int             errors;
        int             results_seen;

        function new();
            int unsigned words;
            int unsigned base;
            words = 128;
            base  = 0;
            for (int k = 0; k < LAYERS; k++)
            begin
                layer_size[k] = words;
                layer_base[k] = base;
                base += words;
                if (words > 2)
                    words = words / 2;
            end
            foreach (light_words[i]) light_words[i] = '0;
            foreach (heavy_words[i]) heavy_words[i] = '0;
            errors       = 0;
            results_seen = 0;
        endfunction

        function automatic int unsigned heavy_index(int unsigned word, int k);
            return layer_base[k] + (word % layer_size[k]);
        endfunction

        function automatic logic [63:0] counter_value(logic [HASH_W-1:0] hash);
            int unsigned word;
            int unsigned pos;
            logic [3:0]  nib;
            logic [63:0] total;
            logic [63:0] heavy_nib;
            word = 32'(hash[13:4]);
            pos  = 32'(hash[3:0]);
            nib  = light_words[word][pos*4 +: 4];
            if (nib < NIB_OVF)
                return {60'b0, nib};
            total = {61'b0, nib[2:0]};
            for (int k = 0; k < LAYERS; k++)
            begin
                heavy_nib = {60'b0, heavy_words[heavy_index(word, k)][pos*4 +: 4]};
                total += heavy_nib << (3 + 4 * k);
            end
            return total;
        endfunction

        // Increment one row counter; return 1 when the carry would run off the top
        function automatic logic bump_counter(logic [HASH_W-1:0] hash);
            int unsigned word;
            int unsigned pos;
            logic [3:0]  nib;
            logic        all_full;
            int unsigned a;
            word = 32'(hash[13:4]);
            pos  = 32'(hash[3:0]);
            nib  = light_words[word][pos*4 +: 4];
            if (nib[2:0] != LOW_FULL)
            begin
                light_words[word][pos*4 +: 4] = nib + 4'd1;
                return 1'b0;
            end
            all_full = 1'b1;
            for (int k = 0; k < LAYERS; k++)
                if (heavy_words[heavy_index(word, k)][pos*4 +: 4] != NIB_FULL)
                begin
                    all_full = 1'b0;
                    break;
                end
            if (all_full)
            begin
                light_words[word][pos*4 +: 4] = NIB_FULL;
                return 1'b1;
            end
            light_words[word][pos*4 +: 4] = (nib == NIB_FULL) ? NIB_OVF : nib + 4'd1;
            for (int k = 0; k < LAYERS; k++)
            begin
                a = heavy_index(word, k);
                if (heavy_words[a][pos*4 +: 4] == NIB_FULL)
                    heavy_words[a][pos*4 +: 4] = 4'h0;
                else
                begin
                    heavy_words[a][pos*4 +: 4] = heavy_words[a][pos*4 +: 4] + 4'd1;
                    break;
                end
            end
            return 1'b0;
        endfunction

        // Note an accepted input transfer and queue its expected result
        function void note_item(logic kind, logic [HASH_W-1:0] hashes [ROWS]);
            sketch_result_t r;
            logic [63:0]    best;
            logic [63:0]    v;
            r = '0;
            if (kind == KIND_INSERT)
            begin
                for (int i = 0; i < ROWS; i++)
                    if (bump_counter(hashes[i]))
                        r.saturated = 1'b1;
            end
            else
            begin
                best = '1;
                for (int i = 0; i < ROWS; i++)
                begin
                    v = counter_value(hashes[i]);
                    if (v < best)
                        best = v;
                end
                r.estimate = best[EST_W-1:0];
            end
            expected_results.insert(expected_results.size(), r);
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch on result %0d: %s got 0x%0h expected 0x%0h",
                     results_seen, what, got, want);
            errors++;
        endtask

        // Compare one accepted output transfer with the oldest expectation
        task check_result(logic [39:0] data, logic flag);
            sketch_result_t want;
            results_seen++;
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected transfer, tdata", 64'(data), 64'd0);
                return;
            end
            want = expected_results.pop_front();
            if (data !== {5'b0, want.estimate})
                report_mismatch("estimate", 64'(data), 64'(want.estimate));
            if (flag !== want.saturated)
                report_mismatch("saturated", 64'(flag), 64'(want.saturated));
        endtask
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;
    logic         m_tuser;

    sketch_scoreboard sketch;
    int               hold_cycles;
    logic [13:0]      hot_counters [4];

    layered_nibble_count_min_sketch DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // Offer one item and hold it until the transfer happens
    task automatic offer_item(logic kind, logic [HASH_W-1:0] hashes [ROWS]);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {hashes[3], hashes[2], hashes[1], hashes[0]};
        do
            @(posedge clk);
        while (!s_tready);
        sketch.note_item(kind, hashes);
    endtask

    task automatic pause_sender(int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Same key in every row
    task automatic offer_key(logic kind, logic [HASH_W-1:0] hash);
        logic [HASH_W-1:0] hashes [ROWS];
        foreach (hashes[i]) hashes[i] = hash;
        offer_item(kind, hashes);
    endtask

    // Hot keys: random upper bits over four fixed counters
    function automatic logic [HASH_W-1:0] hot_hash();
        return {18'($urandom_range(0, 18'h3FFFF)), hot_counters[$urandom_range(0, 3)]};
    endfunction

    // Receiver: check transfers, stall on a shifting pattern, one long hold-off
    initial
    begin
        int stall_mode;
        m_tready    = 1'b0;
        hold_cycles = 0;
        stall_mode  = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                sketch.check_result(m_tdata, m_tuser);
                if (sketch.results_seen == 300)
                    hold_cycles = 600;
                if (sketch.results_seen % 97 == 0)
                    stall_mode = $urandom_range(0, 2);
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_tready <= 1'b0;
            end
            else if (stall_mode == 0)
                m_tready <= 1'b1;
            else if (stall_mode == 1)
                m_tready <= ($urandom_range(0, 3) != 0);
            else
                m_tready <= ($urandom_range(0, 3) == 0);
        end
    end

    // Stimulus
    initial
    begin
        logic [HASH_W-1:0] hashes [ROWS];
        int                burst;
        clk      = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = KIND_INSERT;
        sketch   = new();
        foreach (hot_counters[i]) hot_counters[i] = 14'($urandom_range(0, 14'h3FFF));
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, both kinds, the overflow mark and carries
        offer_key(KIND_QUERY, 32'h0);
        offer_key(KIND_INSERT, 32'h0);
        offer_key(KIND_INSERT, 32'hFFFF_FFFF);
        offer_key(KIND_QUERY, 32'hFFFF_FFFF);
        offer_key(KIND_QUERY, 32'h0);
        hashes[0] = 32'h0000_0005;
        hashes[1] = 32'hFFFF_C005;
        hashes[2] = 32'hAAAA_8005;
        hashes[3] = 32'h5555_4005;
        // every row lands on the same counter: four increments per insert
        repeat (4) offer_item(KIND_INSERT, hashes);
        offer_item(KIND_QUERY, hashes);
        repeat (10) offer_key(KIND_INSERT, 32'h1234_0077);
        offer_key(KIND_QUERY, 32'h1234_0077);
        hashes[0] = 32'h1234_0077;
        hashes[1] = 32'h0;
        hashes[2] = 32'h0000_3FFF;
        hashes[3] = 32'hDEAD_BEEF;
        offer_item(KIND_QUERY, hashes);
        offer_item(KIND_INSERT, hashes);

        // Random: mostly hot keys in bursts, some cold ones
        for (int n = 0; n < 850; )
        begin
            burst = $urandom_range(1, 20);
            for (int b = 0; b < burst; b++, n++)
            begin
                foreach (hashes[i])
                    hashes[i] = ($urandom_range(0, 4) == 0) ? $urandom() : hot_hash();
                offer_item(($urandom_range(0, 3) == 0) ? KIND_QUERY : KIND_INSERT, hashes);
            end
            if ($urandom_range(0, 2) != 0)
                pause_sender($urandom_range(1, 30));
        end
        s_tvalid <= 1'b0;

        // Drain
        while (sketch.expected_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (sketch.errors == 0)
            $display("layered_nibble_count_min_sketch_test: PASS");
        else
            $display("layered_nibble_count_min_sketch_test: FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("layered_nibble_count_min_sketch_test: FAIL");
        $finish;
    end

endmodule
